// ===== hdl/assert_macros.svh =====
// ============================================================================
// Assertion macros
// Shared concurrent assertion shorthands for the distance core.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the reset term is high.
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while the reset term is high.
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/gcd_pkg.sv =====
// ============================================================================
// gcd_pkg
// Widths, fixed-point constants and helpers of the great-circle distance core.
// ============================================================================
package gcd_pkg;

  // Field widths
  localparam int LAT_W    = 28;
  localparam int LON_W    = 29;
  localparam int RADIUS_W = 24;
  localparam int DIST_W   = 26;

  // Internal widths
  localparam int DIFF_W   = 30;  // coordinate difference, signed
  localparam int ZW       = 32;  // half angle in Q30 radians, signed
  localparam int CW       = 34;  // CORDIC datapath, signed
  localparam int MW       = 32;  // multiplier operand, signed Q30
  localparam int SQ_IN_W  = 61;  // square root radicand
  localparam int SQ_OUT_W = 31;  // square root result
  localparam int ANG_W    = 31;  // clamped central half angle

  // Pipeline depths of fixed sections
  localparam int ANG_LAT    = 6;
  localparam int PROD_LAT   = 5;
  localparam int SQRT_STEPS = SQ_OUT_W;

  // Fixed-point constants
  localparam logic [25:0]          HALF_DEG_TO_RAD = 26'd37480660;
  localparam logic signed [CW-1:0] CORDIC_INV_GAIN = 34'sd652032875;
  localparam logic signed [CW-1:0] HALF_PI_Q30     = 34'sd1686629713;
  localparam logic signed [63:0]   Q30_HALF        = 64'sd536870912;

  localparam logic [29:0] ATAN_HEAD [10] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515,  30'd16775850,  30'd8388437,   30'd4194282,   30'd2097149
  };

  // Arctangent of 2^-i in Q30, floor
  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] val;
    if (i < 10) begin
      val = CW'(ATAN_HEAD[i]);
    end else if (i <= 30) begin
      val = CW'((64'd1 << (30 - i)) - 64'd1);
    end else begin
      val = '0;
    end
    return val;
  endfunction

  // Round a Q60 product back to Q30
  function automatic logic signed [MW-1:0] q30_rnd(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = (p + Q30_HALF) >>> 30;
    return MW'(s);
  endfunction

endpackage

// ===== hdl/gcd_if.sv =====
// ============================================================================
// gcd_if
// Valid/ready channels for coordinate words and distance words.
// ============================================================================
interface gcd_coord_if;
  import gcd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] lat_a;
  logic signed [LON_W-1:0] lon_a;
  logic signed [LAT_W-1:0] lat_b;
  logic signed [LON_W-1:0] lon_b;
  modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
  modport sink (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface gcd_dist_if;
  import gcd_pkg::*;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance_m;
  modport source (output valid, distance_m, input ready);
  modport sink (input valid, distance_m, output ready);
endinterface

// ===== hdl/great_circle_distance_core.sv =====
// Throughput: one word per cycle; every stage is registered and the whole pipe
// advances together, so an output stall holds all stages in place.
// Depth is set by the two CORDIC chains and the 31-step square root.
// Reset (rst, synchronous, active high) clears the valid pipe and loads the
// radius register with 6371000 m.
// ============================================================================
// great_circle_distance_core
// Haversine distance between two points, fully pipelined fixed point.
// ============================================================================
`include "assert_macros.svh"

module great_circle_distance_core #(
  parameter int ANGLE_FRAC_BITS = 20,
  parameter int CORDIC_STAGES   = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  gcd_coord_if.sink                     coord,
  gcd_dist_if.source                    result,
  input  logic                          cfg_write,
  input  logic [gcd_pkg::RADIUS_W-1:0] cfg_data
);
  import gcd_pkg::*;

  localparam int LAT = 1 + ANG_LAT + CORDIC_STAGES + PROD_LAT + SQRT_STEPS
                       + CORDIC_STAGES + 2;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;
  localparam logic [ANG_W-1:0]    A_ONE        = 31'd1 << 30;

  logic                en;
  logic [LAT-1:0]      vld;
  logic [RADIUS_W-1:0] radius;

  logic signed [DIFF_W-1:0] dlat0, dlon0, lata0, latb0;
  logic signed [ZW-1:0]     z_dlat, z_dlon, z_lata, z_latb;
  logic signed [CW-1:0]     y_dlat, y_dlon, c_a, s_a, c_b, s_b;

  logic signed [MW-1:0]   yl, yo, ca, sa, cb, sb;
  logic signed [2*MW-1:0] sl_sq, so_sq, ca_sq, sa_sq, cb_sq, sb_sq;
  logic signed [MW-1:0]   s_lat2, s_lon2, cos_a2, cos_b2;
  logic signed [2*MW-1:0] m_cc3;
  logic signed [MW-1:0]   s_lat3, s_lon3;
  logic signed [2*MW-1:0] m4;
  logic signed [MW-1:0]   s_lat4;
  logic signed [MW+1:0]   a_raw;
  logic [ANG_W-1:0]       a_sat5;

  logic [SQ_OUT_W-1:0]  ru, rv;
  logic signed [CW-1:0] z_ang;
  logic [ANG_W-1:0]     ang;
  logic [55:0]          prod;
  logic [56:0]          dist_sum;

  // Advance the whole pipe unless a finished word is held
  assign en           = !result.valid || result.ready;
  assign coord.ready  = en;
  assign result.valid = vld[LAT-1];

  // Hold the radius register
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_write) begin
      radius <= cfg_data;
    end
  end

  // Shift valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], coord.valid};
    end
  end

  // Register differences and latitudes
  always_ff @(posedge clk) begin
    if (en) begin
      dlat0 <= DIFF_W'(coord.lat_b) - DIFF_W'(coord.lat_a);
      dlon0 <= DIFF_W'(coord.lon_b) - DIFF_W'(coord.lon_a);
      lata0 <= DIFF_W'(coord.lat_a);
      latb0 <= DIFF_W'(coord.lat_b);
    end
  end

  // Half angles in radians
  gcd_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_ang_dlat (
    .clk(clk), .en(en), .deg(dlat0), .half_rad(z_dlat));
  gcd_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_ang_dlon (
    .clk(clk), .en(en), .deg(dlon0), .half_rad(z_dlon));
  gcd_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_ang_lata (
    .clk(clk), .en(en), .deg(lata0), .half_rad(z_lata));
  gcd_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_ang_latb (
    .clk(clk), .en(en), .deg(latb0), .half_rad(z_latb));

  // Sines and cosines of the half angles
  gcd_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0)) u_rot_dlat (
    .clk(clk), .en(en), .x_in(CORDIC_INV_GAIN), .y_in('0), .z_in(CW'(z_dlat)),
    .x_out(), .y_out(y_dlat), .z_out());
  gcd_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0)) u_rot_dlon (
    .clk(clk), .en(en), .x_in(CORDIC_INV_GAIN), .y_in('0), .z_in(CW'(z_dlon)),
    .x_out(), .y_out(y_dlon), .z_out());
  gcd_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0)) u_rot_lata (
    .clk(clk), .en(en), .x_in(CORDIC_INV_GAIN), .y_in('0), .z_in(CW'(z_lata)),
    .x_out(c_a), .y_out(s_a), .z_out());
  gcd_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0)) u_rot_latb (
    .clk(clk), .en(en), .x_in(CORDIC_INV_GAIN), .y_in('0), .z_in(CW'(z_latb)),
    .x_out(c_b), .y_out(s_b), .z_out());

  // Values stay within one in Q30, so 32 bits carry them
  assign yl = MW'(y_dlat);
  assign yo = MW'(y_dlon);
  assign ca = MW'(c_a);
  assign sa = MW'(s_a);
  assign cb = MW'(c_b);
  assign sb = MW'(s_b);

  // Form the haversine term, one multiply per stage
  always_ff @(posedge clk) begin
    if (en) begin
      sl_sq  <= yl * yl;
      so_sq  <= yo * yo;
      ca_sq  <= ca * ca;
      sa_sq  <= sa * sa;
      cb_sq  <= cb * cb;
      sb_sq  <= sb * sb;
      s_lat2 <= q30_rnd(sl_sq);
      s_lon2 <= q30_rnd(so_sq);
      cos_a2 <= q30_rnd(ca_sq - sa_sq);
      cos_b2 <= q30_rnd(cb_sq - sb_sq);
      m_cc3  <= cos_a2 * cos_b2;
      s_lat3 <= s_lat2;
      s_lon3 <= s_lon2;
      m4     <= q30_rnd(m_cc3) * s_lon3;
      s_lat4 <= s_lat3;
    end
  end

  // Saturate the term to [0,1]
  assign a_raw = (MW + 2)'(s_lat4) + (MW + 2)'(q30_rnd(m4));

  always_ff @(posedge clk) begin
    if (en) begin
      if (a_raw < 0) begin
        a_sat5 <= '0;
      end else if (a_raw > $signed((MW + 2)'(A_ONE))) begin
        a_sat5 <= A_ONE;
      end else begin
        a_sat5 <= a_raw[ANG_W-1:0];
      end
    end
  end

  // Square roots of a and 1-a
  gcd_isqrt u_sqrt_a (
    .clk(clk), .en(en), .value({a_sat5, 30'd0}), .root(ru));
  gcd_isqrt u_sqrt_b (
    .clk(clk), .en(en), .value({A_ONE - a_sat5, 30'd0}), .root(rv));

  // Arctangent of the two roots
  gcd_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b1)) u_vec (
    .clk(clk), .en(en), .x_in(CW'(rv)), .y_in(CW'(ru)), .z_in('0),
    .x_out(), .y_out(), .z_out(z_ang));

  // Clamp the angle to [0, pi/2]
  always_comb begin
    if (z_ang < 0) begin
      ang = '0;
    end else if (z_ang > HALF_PI_Q30) begin
      ang = ANG_W'(HALF_PI_Q30);
    end else begin
      ang = z_ang[ANG_W-1:0];
    end
  end

  // Scale by the radius and round to whole metres
  assign dist_sum = 57'(prod) + (57'd1 << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      prod              <= 56'(radius) * 56'({ang, 1'b0});
      result.distance_m <= dist_sum[55:30];
    end
  end

  // Checks
  `ASSERT_NEXT(a_rst_clear, clk, 1'b0, rst, !result.valid)
  `ASSERT_IMPLY(a_ready_rule, clk, rst, 1'b1, coord.ready == (!result.valid || result.ready))
  `ASSERT_NEXT(a_stall_freeze, clk, rst, result.valid && !result.ready, $stable(vld))
  `ASSERT_IMPLY(a_sat_range, clk, rst, vld[LAT-SQRT_STEPS-CORDIC_STAGES-3], a_sat5 <= A_ONE)

endmodule

// ===== hdl/gcd_angle.sv =====
// ============================================================================
// gcd_angle
// Wraps a degree angle into [-180,180) and converts it to a Q30 half angle.
// ============================================================================
module gcd_angle #(
  parameter int ANGLE_FRAC_BITS = 20
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [gcd_pkg::DIFF_W-1:0] deg,
  output logic signed [gcd_pkg::ZW-1:0]     half_rad
);
  import gcd_pkg::*;

  localparam logic [63:0] MOD   = 64'd360 << ANGLE_FRAC_BITS;
  localparam logic [63:0] SPAN  = 64'd1 << (DIFF_W - 1);
  localparam logic [63:0] BIAS  = MOD * ((SPAN + MOD - 64'd1) / MOD);
  localparam int          DDW   = $clog2(BIAS + SPAN);
  localparam logic [63:0] RECIP = (64'd1 << DDW) / MOD;
  localparam int          RW    = (RECIP > 0) ? $clog2(RECIP + 64'd1) : 1;
  localparam int          MODW  = $clog2(MOD + 64'd1);
  localparam int          XW    = (DDW > RW + MODW) ? DDW : RW + MODW;
  localparam int          PW    = DDW + RW;
  localparam int          MAGW  = ANGLE_FRAC_BITS + 8;

  localparam logic [DDW-1:0] BIAS_D     = DDW'(BIAS);
  localparam logic [DDW-1:0] MOD_D      = DDW'(MOD);
  localparam logic [DDW-1:0] HALF_MOD_D = DDW'(MOD / 64'd2);
  localparam logic [RW-1:0]  RECIP_R    = RW'(RECIP);

  logic signed [DDW:0] deg_x;
  logic signed [DDW:0] dd_sum;
  logic [DDW-1:0]      dd;
  logic [DDW-1:0]      dd1;
  logic [PW-1:0]       p1;
  logic [DDW-1:0]      dd2;
  logic [XW-1:0]       qm2;
  logic [DDW-1:0]      r_raw;
  logic [DDW-1:0]      r3;
  logic [MAGW-1:0]     mag;
  logic                neg;
  logic [31:0]         q24;
  logic [31:0]         q24_4;
  logic                neg4;
  logic [57:0]         p5;
  logic                neg5;
  logic [57:0]         rad_sum;
  logic [31:0]         rad;

  // Bias the angle to a non-negative value that keeps its residue
  assign deg_x  = (DDW + 1)'(deg);
  assign dd_sum = deg_x + $signed({1'b0, BIAS_D});
  assign dd     = dd_sum[DDW-1:0];

  // Estimate the quotient by reciprocal, then take the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      dd1 <= dd;
      p1  <= PW'(dd) * PW'(RECIP_R);
      dd2 <= dd1;
      qm2 <= XW'(p1[PW-1:DDW]) * XW'(MOD_D);
    end
  end

  // Fix the quotient estimate with one conditional subtract
  assign r_raw = dd2 - qm2[DDW-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      r3 <= (r_raw >= MOD_D) ? r_raw - MOD_D : r_raw;
    end
  end

  // Center into [-180,180) as sign and magnitude
  always_comb begin
    if (r3 >= HALF_MOD_D) begin
      mag = MAGW'(MOD_D - r3);
      neg = 1'b1;
    end else begin
      mag = MAGW'(r3);
      neg = 1'b0;
    end
  end

  // Bring the magnitude to Q24 degrees
  generate
    if (ANGLE_FRAC_BITS <= 24) begin : g_up
      assign q24 = 32'(mag) << (24 - ANGLE_FRAC_BITS);
    end else begin : g_down
      logic [MAGW:0] mag_r;
      assign mag_r = (MAGW + 1)'(mag) + ((MAGW + 1)'(1) << (ANGLE_FRAC_BITS - 25));
      assign q24   = 32'(mag_r >> (ANGLE_FRAC_BITS - 24));
    end
  endgenerate

  // Scale degrees to half-angle radians and restore the sign
  assign rad_sum = p5 + (58'd1 << 25);
  assign rad     = rad_sum[57:26];

  always_ff @(posedge clk) begin
    if (en) begin
      q24_4    <= q24;
      neg4     <= neg;
      p5       <= 58'(q24_4) * 58'(HALF_DEG_TO_RAD);
      neg5     <= neg4;
      half_rad <= neg5 ? -$signed(rad) : $signed(rad);
    end
  end

endmodule

// ===== hdl/gcd_cordic.sv =====
// ============================================================================
// gcd_cordic
// Unrolled CORDIC, one registered micro-rotation per stage; rotation or
// vectoring mode.
// ============================================================================
module gcd_cordic #(
  parameter int STAGES = 24,
  parameter bit VECTOR = 1'b0
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [gcd_pkg::CW-1:0] x_in,
  input  logic signed [gcd_pkg::CW-1:0] y_in,
  input  logic signed [gcd_pkg::CW-1:0] z_in,
  output logic signed [gcd_pkg::CW-1:0] x_out,
  output logic signed [gcd_pkg::CW-1:0] y_out,
  output logic signed [gcd_pkg::CW-1:0] z_out
);
  import gcd_pkg::*;

  logic signed [CW-1:0] xs [STAGES+1];
  logic signed [CW-1:0] ys [STAGES+1];
  logic signed [CW-1:0] zs [STAGES+1];

  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign zs[0] = z_in;

  // Rotate toward zero angle (rotation) or toward the x axis (vectoring)
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [CW-1:0] AT = atan_q30(i);
    logic pos;
    assign pos = VECTOR ? (ys[i] < 0) : (zs[i] >= 0);

    always_ff @(posedge clk) begin
      if (en) begin
        if (pos) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - AT;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + AT;
        end
      end
    end
  end

  assign x_out = xs[STAGES];
  assign y_out = ys[STAGES];
  assign z_out = zs[STAGES];

endmodule

// ===== hdl/gcd_isqrt.sv =====
// ============================================================================
// gcd_isqrt
// Pipelined floor square root, one result bit per registered stage.
// ============================================================================
module gcd_isqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [gcd_pkg::SQ_IN_W-1:0]  value,
  output logic [gcd_pkg::SQ_OUT_W-1:0] root
);
  import gcd_pkg::*;

  localparam int SW = SQ_IN_W + 1;

  logic [SW-1:0] vs [SQRT_STEPS];
  logic [SW-1:0] rs [SQRT_STEPS+1];

  assign vs[0] = SW'(value);
  assign rs[0] = '0;

  // Try each bit pair from the top down
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (SQRT_STEPS - 1 - j));
    logic [SW-1:0] trial;
    logic          fits;
    assign trial = rs[j] + BIT;
    assign fits  = vs[j] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rs[j+1] <= fits ? (rs[j] >> 1) + BIT : rs[j] >> 1;
      end
    end

    if (j < SQRT_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          vs[j+1] <= fits ? vs[j] - trial : vs[j];
        end
      end
    end
  end

  assign root = rs[SQRT_STEPS][SQ_OUT_W-1:0];

endmodule

// ===== dv/great_circle_distance_core_tb.sv =====
// ============================================================================
// great_circle_distance_core_tb
// Drives coordinate words into the haversine core under random idling and
// one long output stall, predicts distance words in fixed point or takes a
// known value, and checks every distance word in order against the expectation.
// ============================================================================
module great_circle_distance_core_tb;
  import gcd_pkg::*;

  localparam int  PIPE_LAT   = 45 + 2 * 24;
  localparam int  WDOG_LIMIT = 20000;
  localparam int  N_RANDOM   = 1800;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [RADIUS_W-1:0] cfg_data;

  gcd_coord_if coord ();
  gcd_dist_if  result ();

  great_circle_distance_core dut (
    .clk       (clk),
    .rst       (rst),
    .coord     (coord.sink),
    .result    (result.source),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  typedef struct {
    logic signed [LAT_W-1:0] lat_a;
    logic signed [LON_W-1:0] lon_a;
    logic signed [LAT_W-1:0] lat_b;
    logic signed [LON_W-1:0] lon_b;
    longint                  known;  // -1 when only the predictor applies
  } coord_row_t;

  logic [DIST_W-1:0]   dist_queue [$];
  logic [RADIUS_W-1:0] radius_m;
  int  n_errors;
  int  idle_cycles;
  bit  stall_long;
  bit  no_idle;
  bit  stim_done;

  // Arithmetic shift right with floor
  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(int i);
    longint tbl [10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                         33543515, 16775850, 8388437, 4194282, 2097149};
    if (i < 10) return tbl[i];
    if (i <= 30) return (64'sd1 << (30 - i)) - 1;
    return 0;
  endfunction

  // Degrees in Q20 to half angle in Q30 radians
  function automatic longint to_half_rad(longint d);
    longint m, r, q24, rad;
    bit neg;
    m = 64'sd360 << 20;
    r = d % m;
    if (r < 0) r += m;
    if (r >= m / 2) r -= m;
    neg = r < 0;
    q24 = (neg ? -r : r) << 4;
    rad = (q24 * 37480660 + (64'sd1 << 25)) >>> 26;
    return neg ? -rad : rad;
  endfunction

  function automatic void rotate(input longint z0, output longint xo, output longint yo);
    longint x, y, z, nx;
    x = 652032875; y = 0; z = z0;
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        nx = x - sra(y, i); y = y + sra(x, i); z -= atan_step(i);
      end else begin
        nx = x + sra(y, i); y = y - sra(x, i); z += atan_step(i);
      end
      x = nx;
    end
    xo = x; yo = y;
  endfunction

  function automatic longint vector_angle(longint y0, longint x0);
    longint x, y, z, nx;
    x = x0; y = y0; z = 0;
    for (int i = 0; i < 24; i++) begin
      if (y >= 0) begin
        nx = x + sra(y, i); y = y - sra(x, i); z += atan_step(i);
      end else begin
        nx = x - sra(y, i); y = y + sra(x, i); z -= atan_step(i);
      end
      x = nx;
    end
    if (z < 0) z = 0;
    if (z > 1686629713) z = 1686629713;
    return z;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0; bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv; res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  // Haversine distance in whole metres for one coordinate word
  function automatic logic [DIST_W-1:0] predict_distance(coord_row_t w,
                                                         logic [RADIUS_W-1:0] rad_m);
    longint la, oa, lb, ob, c, s, s_lat, s_lon, cos_a, cos_b, a, u, v, ang;
    longint unsigned d;
    la = w.lat_a; oa = w.lon_a; lb = w.lat_b; ob = w.lon_b;
    rotate(to_half_rad(lb - la), c, s);
    s_lat = (s * s + (64'sd1 << 29)) >>> 30;
    rotate(to_half_rad(ob - oa), c, s);
    s_lon = (s * s + (64'sd1 << 29)) >>> 30;
    rotate(to_half_rad(la), c, s);
    cos_a = (c * c - s * s + (64'sd1 << 29)) >>> 30;
    rotate(to_half_rad(lb), c, s);
    cos_b = (c * c - s * s + (64'sd1 << 29)) >>> 30;
    a = s_lat + mul_q30(mul_q30(cos_a, cos_b), s_lon);
    if (a < 0) a = 0;
    if (a > (64'sd1 << 30)) a = 64'sd1 << 30;
    u = int_sqrt(longint'(a) << 30);
    v = int_sqrt(longint'((64'sd1 << 30) - a) << 30);
    ang = vector_angle(u, v);
    d = (longint'(rad_m) * (2 * ang) + (64'sd1 << 29)) >> 30;
    return d[DIST_W-1:0];
  endfunction

  function automatic coord_row_t random_coord();
    coord_row_t w;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      // raw bit patterns, out of range wraps
      w.lat_a = LAT_W'($urandom); w.lon_a = LON_W'($urandom);
      w.lat_b = LAT_W'($urandom); w.lon_b = LON_W'($urandom);
    end else if (mode == 1) begin
      // near-coincident and near-antipodal pairs
      w.lat_a = LAT_W'($signed($urandom_range(0, 188743680)) - 94371840);
      w.lon_a = LON_W'($signed($urandom_range(0, 377487360)) - 188743680);
      w.lat_b = ($urandom_range(0, 1))
                ? LAT_W'(w.lat_a + $signed($urandom_range(0, 64)) - 32)
                : -w.lat_a;
      w.lon_b = LON_W'(w.lon_a + (($urandom_range(0, 1)) ? 29'sd188743680 : 29'sd0)
                       + $signed($urandom_range(0, 64)) - 32);
    end else begin
      w.lat_a = LAT_W'($signed($urandom_range(0, 188743680)) - 94371840);
      w.lon_a = LON_W'($signed($urandom_range(0, 377487360)) - 188743680);
      w.lat_b = LAT_W'($signed($urandom_range(0, 188743680)) - 94371840);
      w.lon_b = LON_W'($signed($urandom_range(0, 377487360)) - 188743680);
    end
    w.known = -1;
    return w;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one coordinate word and hold it until accepted
  task automatic send_coord(coord_row_t w);
    while (!no_idle && $urandom_range(0, 99) < 9) begin
      coord.valid <= 1'b0;
      @(negedge clk);
    end
    coord.valid <= 1'b1;
    coord.lat_a <= w.lat_a; coord.lon_a <= w.lon_a;
    coord.lat_b <= w.lat_b; coord.lon_b <= w.lon_b;
    @(posedge clk);
    while (!coord.ready) @(posedge clk);
    if (w.known >= 0) dist_queue.insert(dist_queue.size(), DIST_W'(w.known));
    else dist_queue.insert(dist_queue.size(), predict_distance(w, radius_m));
    @(negedge clk);
  endtask

  // Drain, let the pipe settle, then load a new radius
  task automatic set_radius(logic [RADIUS_W-1:0] r);
    coord.valid <= 1'b0;
    while (dist_queue.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 5) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= r;
    @(negedge clk);
    cfg_write <= 1'b0;
    radius_m = r;
  endtask

  // Stimulus
  initial begin
    coord_row_t dir_rows [14];
    coord_row_t zero_rows [2];
    coord_row_t w;
    logic [RADIUS_W-1:0] radii [5];
    radii = '{24'd1, 24'd16777215, 24'd0, 24'd6378137, 24'd6371000};
    rst = 1'b1; cfg_write = 1'b0; cfg_data = '0; coord.valid = 1'b0;
    coord.lat_a = '0; coord.lon_a = '0; coord.lat_b = '0; coord.lon_b = '0;
    stall_long = 1'b0; no_idle = 1'b0; stim_done = 1'b0;
    radius_m = 24'd6371000;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed rows: same point gives zero, others go through the predictor
    dir_rows = '{
      '{28'sd0, 29'sd0, 28'sd0, 29'sd0, 0},
      '{28'sd94371840, 29'sd0, 28'sd94371840, 29'sd100, 0},
      '{28'sd94371840, 29'sd0, -28'sd94371840, 29'sd0, -1},
      '{28'sd0, 29'sd0, 28'sd0, 29'sd188743680, -1},
      '{28'sd0, -29'sd188743680, 28'sd0, 29'sd188743680, -1},
      '{28'sd0, 29'sd188743680, 28'sd0, -29'sd188743680, -1},
      '{-28'sd94371840, -29'sd188743680, 28'sd94371840, 29'sd188743679, -1},
      '{28'h7ffffff, 29'h0fffffff, 28'h8000000, 29'h10000000, -1},
      '{28'h8000000, 29'h10000000, 28'h7ffffff, 29'h0fffffff, -1},
      '{28'hfffffff, 29'h1fffffff, 28'sd1, 29'sd1, -1},
      '{28'sd47185920, 29'sd0, -28'sd47185920, 29'sd188743680, -1},
      '{28'sd0, 29'sd0, 28'sd1, 29'sd1, -1},
      '{28'sd53739520, 29'sd2097152, 28'sd42991616, -29'sd77594624, -1},
      '{28'sd1000, 29'sd0, -28'sd1000, 29'sd188743680, -1}
    };
    foreach (dir_rows[i]) send_coord(dir_rows[i]);

    // Zero radius gives zero distance
    set_radius(24'd0);
    zero_rows = '{
      '{28'sd94371840, 29'sd0, -28'sd94371840, 29'sd0, 0},
      '{28'sd0, 29'sd0, 28'sd0, 29'sd188743680, 0}
    };
    foreach (zero_rows[i]) send_coord(zero_rows[i]);

    // Random phases over several radii
    for (int p = 0; p < 5; p++) begin
      set_radius(radii[p] == 0 ? 24'($urandom_range(1, 16777215)) : radii[p]);
      for (int k = 0; k < N_RANDOM / 5; k++) begin
        no_idle = (p == 2);
        if (p == 1 && k == 50) stall_long = 1'b1;
        if (p == 3 && k == 100) begin
          // pause until every distance word has arrived
          coord.valid <= 1'b0;
          while (dist_queue.size() != 0) @(negedge clk);
        end
        w = random_coord();
        send_coord(w);
      end
    end
    coord.valid <= 1'b0;
    no_idle = 1'b0;
    stim_done = 1'b1;
  end

  // Receiver ready with random idling and one long hold-off
  initial begin
    int hold;
    result.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (stall_long) begin
        stall_long = 1'b0;
        result.ready <= 1'b0;
        hold = 0;
        while (hold < 400) begin
          @(negedge clk);
          hold++;
        end
      end
      result.ready <= no_idle || ($urandom_range(0, 99) >= 9);
      @(negedge clk);
    end
  end

  // Check distance words against expectations
  always @(posedge clk) begin
    logic [DIST_W-1:0] want;
    if (!rst && result.valid && result.ready) begin
      if (dist_queue.size() == 0) begin
        $error("distance_m: unexpected word, actual %0d", result.distance_m);
        n_errors++;
      end else begin
        want = dist_queue.pop_front();
        if (result.distance_m !== want) begin
          $error("distance_m: expected %0d, actual %0d", want, result.distance_m);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word, then end of run
  initial begin
    n_errors = 0;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((coord.valid && coord.ready) || (result.valid && result.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
      if (stim_done && dist_queue.size() == 0) begin
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (n_errors == 0 && dist_queue.size() == 0) begin
          $display("ALL CHECKS PASSED");
        end else begin
          $display("CHECKS FAILED");
        end
        $finish;
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/gcd_pkg.sv
hdl/gcd_if.sv
hdl/gcd_angle.sv
hdl/gcd_cordic.sv
hdl/gcd_isqrt.sv
hdl/great_circle_distance_core.sv
dv/great_circle_distance_core_tb.sv
